>>> sv/dhoat_pkg.sv
// ----------------------------------------------------------------------------
// dhoat_pkg: shared types and codes for the double hash table
// Request and result beat layouts, job format between front and back, codes.
// ----------------------------------------------------------------------------
package dhoat_pkg;

    // Default table geometry.
    localparam int DEF_CAPACITY   = 61;
    localparam int DEF_STEP_PRIME = 59;

    // Width of slot indexes in the job format; covers the largest capacity.
    localparam int JOB_IDX_W = 16;

    // Request actions.
    localparam logic [1:0] ACT_SEARCH = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // Slot tags.
    localparam logic [1:0] TAG_EMPTY    = 2'd0;
    localparam logic [1:0] TAG_OCCUPIED = 2'd1;
    localparam logic [1:0] TAG_DELETED  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key_value;
    } t_req;

    typedef struct packed {
        logic       success;
        logic [5:0] stored_count;
        logic       is_empty;
        logic       is_full;
    } t_res;

    // A classified request: key plus its home slot and probe step.
    typedef struct packed {
        logic [1:0]           action;
        logic [31:0]          key_value;
        logic [JOB_IDX_W-1:0] home;
        logic [JOB_IDX_W-1:0] step;
    } t_job;

endpackage

>>> sv/dhoat_front.sv
// ----------------------------------------------------------------------------
// dhoat_front: request intake and hash computation
// Reduces the key modulo the capacity and the step prime four bits a cycle,
// then reduces the step modulo the capacity, and hands the job onward.
// ----------------------------------------------------------------------------
module dhoat_front #(
    parameter int CAPACITY   = 61,
    parameter int STEP_PRIME = 59
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hold,
    input  logic              i_push,
    input  dhoat_pkg::t_req   i_req,
    output logic              o_full,
    output logic              o_job_push,
    output dhoat_pkg::t_job   o_job,
    input  logic              i_job_full
);
    import dhoat_pkg::*;

    localparam int IW  = $clog2(CAPACITY);
    localparam int PW  = $clog2(STEP_PRIME + 1);
    localparam int SCH = (PW + 3) / 4;
    localparam int SPW = SCH * 4;

    localparam logic [IW:0] NMOD = (IW+1)'(CAPACITY);
    localparam logic [PW:0] PMOD = (PW+1)'(STEP_PRIME);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MODV = 2'd1;
    localparam logic [1:0] F_MODS = 2'd2;
    localparam logic [1:0] F_HOLD = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [2:0]    r_cnt, n_cnt;
    logic [31:0]   r_sh, n_sh;
    logic [1:0]    r_act, n_act;
    logic [31:0]   r_key, n_key;
    logic [IW-1:0] r_hv, n_hv;
    logic [PW-1:0] r_pv, n_pv;
    logic [IW-1:0] r_sv, n_sv;
    logic          w_accept;

    assign o_full   = (r_state != F_IDLE) || i_hold;
    assign w_accept = i_push && !o_full;

    // Next-state logic with the four-bit residue steps.
    always_comb begin
        logic [3:0]    nib;
        logic [IW:0]   th;
        logic [PW:0]   tp;
        logic [IW-1:0] hv;
        logic [PW-1:0] pv;
        logic [IW-1:0] sv;
        logic [PW:0]   s;
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sh    = r_sh;
        n_act   = r_act;
        n_key   = r_key;
        n_hv    = r_hv;
        n_pv    = r_pv;
        n_sv    = r_sv;
        nib = r_sh[31:28];
        hv  = r_hv;
        pv  = r_pv;
        sv  = r_sv;
        for (int j = 0; j < 4; j++) begin
            th = {hv, nib[3-j]};
            if (th >= NMOD) begin
                th = th - NMOD;
            end
            hv = th[IW-1:0];
            tp = {pv, nib[3-j]};
            if (tp >= PMOD) begin
                tp = tp - PMOD;
            end
            pv = tp[PW-1:0];
            th = {sv, nib[3-j]};
            if (th >= NMOD) begin
                th = th - NMOD;
            end
            sv = th[IW-1:0];
        end
        s = PMOD - {1'b0, r_pv};
        case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_act   = i_req.action;
                    n_key   = i_req.key_value;
                    n_sh    = i_req.key_value;
                    n_hv    = '0;
                    n_pv    = '0;
                    n_cnt   = '0;
                    n_state = F_MODV;
                end
            end
            F_MODV: begin
                n_hv  = hv;
                n_pv  = pv;
                n_sh  = {r_sh[27:0], 4'b0};
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = F_MODS;
                    n_cnt   = '0;
                end
            end
            F_MODS: begin
                if (r_cnt == 3'd0) begin
                    // Load the step, top aligned, and start from a zero residue.
                    n_sh  = {SPW'(s[PW-1:0]), (32-SPW)'(0)};
                    n_sv  = '0;
                    n_cnt = 3'd1;
                end else begin
                    n_sv  = sv;
                    n_sh  = {r_sh[27:0], 4'b0};
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'(SCH)) begin
                        n_state = F_HOLD;
                    end
                end
            end
            F_HOLD: begin
                if (!i_job_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign o_job_push = (r_state == F_HOLD) && !i_job_full;
    assign o_job = '{action: r_act, key_value: r_key,
                     home: JOB_IDX_W'(r_hv), step: JOB_IDX_W'(r_sv)};

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_sh  <= n_sh;
        r_act <= n_act;
        r_key <= n_key;
        r_hv  <= n_hv;
        r_pv  <= n_pv;
        r_sv  <= n_sv;
    end

endmodule

>>> sv/dhoat_queue.sv
// ----------------------------------------------------------------------------
// dhoat_queue: two-entry job queue
// Decouples hash computation from the probe engine.
// ----------------------------------------------------------------------------
module dhoat_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dhoat_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output dhoat_pkg::t_job o_job
);
    import dhoat_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= !r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && !o_empty) ? 1 : 0);
        end
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

>>> sv/dhoat_back.sv
// ----------------------------------------------------------------------------
// dhoat_back: probe engine and slot storage
// Walks the probe sequence over the key and tag memories, an issue state then
// a check state per slot, applies the update and posts the result beat.
// ----------------------------------------------------------------------------
module dhoat_back #(
    parameter int CAPACITY = 61
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  dhoat_pkg::t_job i_job,
    output logic            o_q_pop,
    output logic            o_clearing,
    output logic            o_empty,
    input  logic            i_pop,
    output dhoat_pkg::t_res o_res
);
    import dhoat_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [IW:0]   NMOD = (IW+1)'(CAPACITY);
    localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL = CW'(CAPACITY);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [31:0]   r_key_mem [CAPACITY];
    logic [1:0]    r_tag_mem [CAPACITY];
    logic [31:0]   r_rd_key;
    logic [1:0]    r_rd_tag;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_pos, n_pos;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_step, n_step;
    logic [1:0]    r_act, n_act;
    logic [31:0]   r_key, n_key;
    logic          r_ok, n_ok;
    logic [CW-1:0] r_count, n_count;
    logic          r_res_valid;
    t_res          r_res;

    logic          w_tag_we, w_key_we;
    logic [1:0]    w_tag_wd;
    logic          w_load;
    logic [IW:0]   w_sum;
    logic [IW-1:0] w_next;

    // Next slot on the probe sequence.
    always_comb begin
        w_sum = {1'b0, r_pos} + {1'b0, r_step};
        if (w_sum >= NMOD) begin
            w_sum = w_sum - NMOD;
        end
        w_next = w_sum[IW-1:0];
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_q_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign w_load     = (r_state == S_DONE) && (!r_res_valid || i_pop);

    // Probe control.
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_i      = r_i;
        n_step   = r_step;
        n_act    = r_act;
        n_key    = r_key;
        n_ok     = r_ok;
        n_count  = r_count;
        w_tag_we = 1'b0;
        w_key_we = 1'b0;
        w_tag_wd = TAG_EMPTY;
        case (r_state)
            S_CLEAR: begin
                w_tag_we = 1'b1;
                n_pos    = r_pos + IW'(1);
                if (r_pos == LAST) begin
                    // Park the address on a valid slot once the pass ends.
                    n_pos   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_act  = i_job.action;
                    n_key  = i_job.key_value;
                    n_pos  = i_job.home[IW-1:0];
                    n_step = i_job.step[IW-1:0];
                    n_i    = '0;
                    n_ok   = 1'b0;
                    if (i_job.action == ACT_SEARCH || i_job.action == ACT_REMOVE ||
                        (i_job.action == ACT_INSERT && r_count < FULL)) begin
                        n_state = S_ISSUE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ISSUE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_act == ACT_INSERT && r_rd_tag != TAG_OCCUPIED) begin
                    w_key_we = 1'b1;
                    w_tag_we = 1'b1;
                    w_tag_wd = TAG_OCCUPIED;
                    n_count  = r_count + CW'(1);
                    n_ok     = 1'b1;
                    n_state  = S_DONE;
                end else if (r_act != ACT_INSERT && r_rd_tag == TAG_EMPTY) begin
                    n_state = S_DONE;
                end else if (r_act != ACT_INSERT && r_rd_tag == TAG_OCCUPIED &&
                             r_rd_key == r_key) begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                    if (r_act == ACT_REMOVE) begin
                        w_tag_we = 1'b1;
                        w_tag_wd = TAG_DELETED;
                        n_count  = r_count - CW'(1);
                    end
                end else if (r_i == LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_pos   = w_next;
                    n_state = S_ISSUE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Slot memories, one write and one registered read at the probe slot.
    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            r_tag_mem[r_pos] <= w_tag_wd;
        end
        if (w_key_we) begin
            r_key_mem[r_pos] <= r_key;
        end
        r_rd_tag <= r_tag_mem[r_pos];
        r_rd_key <= r_key_mem[r_pos];
    end

    // Control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_count <= n_count;
            if (w_load) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
        r_i    <= n_i;
        r_step <= n_step;
        r_act  <= n_act;
        r_key  <= n_key;
        r_ok   <= n_ok;
        if (w_load) begin
            r_res <= '{success: r_ok, stored_count: 6'(r_count),
                       is_empty: (r_count == '0), is_full: (r_count == FULL)};
        end
    end

    assign o_empty = !r_res_valid;
    assign o_res   = r_res;

    // The stored count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("stored count above capacity");

    // No job is taken from the queue while the tag memory is being cleared.
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_q_pop)
        else $error("job popped during clearing pass");

    // An insert only completes with a success when the table had room.
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_key_we) |-> (r_count < FULL))
        else $error("insert into a full table");

    // A posted result stays until it is taken.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_pop) |=> (r_res_valid && $stable(r_res)))
        else $error("result beat dropped or changed while waiting");

endmodule

>>> sv/double_hash_open_address_table.sv
// ----------------------------------------------------------------------------
// double_hash_open_address_table: open-addressed table with double hashing
// Search, insert and remove of 32-bit keys over a tagged slot memory.
// ----------------------------------------------------------------------------
// Flow: the front reduces the key four bits at a time, then the step, and
// queues the job; the probe engine issues and checks one slot per probe.
// The front takes one request at a time but works on the next while the
// probe engine runs; the probe loop over the slot memory, one read per
// probe, usually sets the pace. Reset: a clearing pass writes every tag
// empty, with full held high until it ends.
module double_hash_open_address_table #(
    parameter int CAPACITY   = dhoat_pkg::DEF_CAPACITY,
    parameter int STEP_PRIME = dhoat_pkg::DEF_STEP_PRIME
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  dhoat_pkg::t_req i_req,
    output logic            empty,
    input  logic            pop,
    output dhoat_pkg::t_res o_res
);
    import dhoat_pkg::*;

    logic w_clearing;
    logic w_job_push, w_job_full, w_job_pop, w_job_empty;
    t_job w_job_in, w_job_out;

    // Request intake and hashing.
    dhoat_front #(.CAPACITY(CAPACITY), .STEP_PRIME(STEP_PRIME)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (w_clearing),
        .i_push     (push),
        .i_req      (i_req),
        .o_full     (full),
        .o_job_push (w_job_push),
        .o_job      (w_job_in),
        .i_job_full (w_job_full)
    );

    // Job queue between the two halves.
    dhoat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_empty (w_job_empty),
        .o_job   (w_job_out)
    );

    // Probe engine and result beat.
    dhoat_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_job_empty),
        .i_job      (w_job_out),
        .o_q_pop    (w_job_pop),
        .o_clearing (w_clearing),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_res      (o_res)
    );

endmodule

>>> tb/sv/tb_double_hash_open_address_table.sv
// ----------------------------------------------------------------------------
// tb_double_hash_open_address_table: self-checking bench for the hash table
// Drives search, insert, remove and unused-action beats with random gaps and
// a long output stall, predicts each result with a behavioral copy of the
// table, and checks every result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_double_hash_open_address_table;
    timeunit 1ns;
    timeprecision 1ps;

    import dhoat_pkg::*;

    localparam int NSLOT = DEF_CAPACITY;
    localparam int PRIME = DEF_STEP_PRIME;
    localparam int CYCLE_LIMIT = 2000000;

    // The one action code that the table does not use.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    t_req i_req = '0;
    t_res o_res;

    // Behavioral copy of the table.
    logic [31:0] tbl_key [NSLOT];
    logic [1:0]  tbl_tag [NSLOT];
    int          tbl_count;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_hits = 0;
    int   cycle_count = 0;
    int   stall_left = 0;
    bit   stim_done = 1'b0;
    bit   long_hold = 1'b0;
    int   hold_left = 0;
    logic [31:0] recent_keys[$];

    double_hash_open_address_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Position of the occupied slot that holds the key, or -1.
    function automatic int find_slot(logic [31:0] v);
        int pos;
        int stp;
        pos = v % NSLOT;
        stp = (PRIME - (v % PRIME)) % NSLOT;
        for (int i = 0; i < NSLOT; i++) begin
            if (tbl_tag[pos] == TAG_EMPTY) return -1;
            if (tbl_tag[pos] == TAG_OCCUPIED && tbl_key[pos] == v) return pos;
            pos = (pos + stp) % NSLOT;
        end
        return -1;
    endfunction

    // Apply one request to the table copy and return the expected result.
    function automatic t_res table_apply(t_req r);
        t_res res;
        bit ok;
        int pos;
        int stp;
        ok = 1'b0;
        case (r.action)
            ACT_SEARCH: begin
                ok = find_slot(r.key_value) >= 0;
            end
            ACT_INSERT: begin
                if (tbl_count < NSLOT) begin
                    pos = r.key_value % NSLOT;
                    stp = (PRIME - (r.key_value % PRIME)) % NSLOT;
                    for (int i = 0; i < NSLOT && !ok; i++) begin
                        if (tbl_tag[pos] != TAG_OCCUPIED) begin
                            tbl_key[pos] = r.key_value;
                            tbl_tag[pos] = TAG_OCCUPIED;
                            tbl_count++;
                            ok = 1'b1;
                        end else begin
                            pos = (pos + stp) % NSLOT;
                        end
                    end
                end
            end
            ACT_REMOVE: begin
                pos = find_slot(r.key_value);
                if (pos >= 0) begin
                    tbl_tag[pos] = TAG_DELETED;
                    if (tbl_count > 0) tbl_count--;
                    ok = 1'b1;
                end
            end
            default: ok = 1'b0;
        endcase
        res.success = ok;
        res.stored_count = tbl_count[5:0];
        res.is_empty = (tbl_count == 0);
        res.is_full = (tbl_count == NSLOT);
        return res;
    endfunction

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_req(logic [1:0] act, logic [31:0] v);
        t_req r;
        r.action = act;
        r.key_value = v;
        pending_reqs.push_back(r);
        if (act == ACT_INSERT) begin
            recent_keys.push_back(v);
            if (recent_keys.size() > 80) void'(recent_keys.pop_front());
        end
    endtask

    function automatic logic [31:0] pick_key();
        if (recent_keys.size() > 0 && $urandom_range(0, 99) < 70)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        if ($urandom_range(0, 1)) return $urandom();
        return $urandom_range(0, 400);
    endfunction

    // Stimulus: directed edge cases, then random traffic.
    initial begin
        logic [1:0] act;
        int roll;
        for (int i = 0; i < NSLOT; i++) tbl_tag[i] = TAG_EMPTY;
        tbl_count = 0;
        queue_req(ACT_SEARCH, 32'd0);
        queue_req(ACT_REMOVE, 32'hFFFF_FFFF);
        queue_req(ACT_INSERT, 32'd0);
        queue_req(ACT_INSERT, 32'hFFFF_FFFF);
        queue_req(ACT_INSERT, 32'd0);
        queue_req(ACT_INSERT, 32'd61);
        queue_req(ACT_INSERT, 32'd122);
        queue_req(ACT_SEARCH, 32'd122);
        queue_req(ACT_REMOVE, 32'd61);
        queue_req(ACT_SEARCH, 32'd122);
        queue_req(ACT_INSERT, 32'd183);
        queue_req(ACT_UNUSED, 32'hA5A5_5A5A);
        queue_req(ACT_REMOVE, 32'd0);
        queue_req(ACT_REMOVE, 32'd0);
        queue_req(ACT_REMOVE, 32'd0);
        queue_req(ACT_SEARCH, 32'hFFFF_FFFF);
        queue_req(ACT_INSERT, 32'd59);
        queue_req(ACT_INSERT, 32'h5555_5555);
        queue_req(ACT_INSERT, 32'hAAAA_AAAA);
        // Fill until full, then try more inserts.
        for (int i = 0; i < 66; i++) queue_req(ACT_INSERT, 32'd1000 + i * 7);
        queue_req(ACT_SEARCH, 32'd1000);
        // Random traffic, weighted toward keys already stored.
        for (int i = 0; i < 1500; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) act = ACT_INSERT;
            else if (roll < 65) act = ACT_SEARCH;
            else if (roll < 97) act = ACT_REMOVE;
            else act = ACT_UNUSED;
            queue_req(act, pick_key());
        end
    end

    // Driver: feeds one request beat at a time with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !full) begin
            expected_results.push_back(table_apply(i_req));
            stall_left = gap_len();
            if (stall_left == 0 && pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end else if (!push) begin
            if (stall_left > 0) begin
                stall_left--;
            end else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                push <= 1'b1;
            end
        end
    end

    // Long output hold-off once, after the sixtieth checked result, during the fill.
    always @(posedge i_clk) begin
        if (!long_hold && n_checked == 60) begin
            long_hold <= 1'b1;
            hold_left <= 1500;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: pops result beats and compares them in order.
    int pop_wait = 0;
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (want.success) n_hits++;
                    if (o_res.success !== want.success) begin
                        $error("success: expected %0d, got %0d", want.success, o_res.success);
                        n_errors++;
                    end
                    if (o_res.stored_count !== want.stored_count) begin
                        $error("stored_count: expected %0d, got %0d",
                               want.stored_count, o_res.stored_count);
                        n_errors++;
                    end
                    if (o_res.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, o_res.is_empty);
                        n_errors++;
                    end
                    if (o_res.is_full !== want.is_full) begin
                        $error("is_full: expected %0d, got %0d", want.is_full, o_res.is_full);
                        n_errors++;
                    end
                end
            end
            if (hold_left > 0 || (long_hold == 1'b0 && n_checked == 60)) begin
                pop <= 1'b0;
            end else if (pop_wait > 0) begin
                pop_wait <= pop_wait - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0) pop_wait <= gap_len();
            end
        end
    end

    // Reset, completion and timeout.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !push && expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Checked %0d result beats, %0d successful, with a long output stall.",
                 n_checked, n_hits);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("tb_double_hash_open_address_table OK");
        else
            $display("tb_double_hash_open_address_table NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("tb_double_hash_open_address_table NOT OK");
            $finish;
        end
    end

endmodule

>>> double_hash_open_address_table.f
sv/dhoat_pkg.sv
sv/dhoat_front.sv
sv/dhoat_queue.sv
sv/dhoat_back.sv
sv/double_hash_open_address_table.sv
tb/sv/tb_double_hash_open_address_table.sv
